>>> hw/rtl/matrix_4x4_compose_multiply_defines.svh
// Assertion macros shared by the matrix compose-multiply RTL.
`ifndef MATRIX_4X4_COMPOSE_MULTIPLY_DEFINES_SVH
`define MATRIX_4X4_COMPOSE_MULTIPLY_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcm assertion failed");

// Next-cycle implication.
`define MCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcm assertion failed");

`else

`define MCM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MCM_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/mcm_pkg.sv
// Shared types and constants for the matrix compose-multiply block.
package mcm_pkg;

    // Element index field width on the ports
    localparam int IDX_W = 4;

    // Defaults for the top-level parameters
    localparam int DIM_DEF        = 4;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Token flowing down the cell chain
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tok;

    // Element write request broadcast to all cells
    typedef struct packed {
        logic             en;
        logic             mode;
        logic [IDX_W-1:0] idx;
    } t_wr;

    // Write targets
    localparam logic MODE_KEPT  = 1'b0;
    localparam logic MODE_RIGHT = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_seq_state;

endpackage

>>> hw/rtl/mcm_cell.sv
// One multiply-accumulate cell: holds one kept column and one right-operand row.
module mcm_cell #(
    parameter int DIM        = 4,
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int CELL       = 0,
    parameter int RC_W       = 2,
    parameter int ACC_W      = 66
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_bank,
    input  mcm_pkg::t_wr                 i_wr,
    input  logic [DATA_WIDTH-1:0]        i_wr_value,
    input  logic                         i_res_we,
    input  logic [RC_W-1:0]              i_res_slot,
    input  logic [DATA_WIDTH-1:0]        i_res_value,
    input  mcm_pkg::t_tok                i_tok,
    input  logic [RC_W-1:0]              i_r,
    input  logic [RC_W-1:0]              i_c,
    input  logic signed [ACC_W-1:0]      i_acc,
    output mcm_pkg::t_tok                o_tok,
    output logic [RC_W-1:0]              o_r,
    output logic [RC_W-1:0]              o_c,
    output logic signed [ACC_W-1:0]      o_acc
);
    import mcm_pkg::*;

    // Reset value of the diagonal: 1.0, clipped to the largest value
    localparam logic [DATA_WIDTH-1:0] L_ONE = (FRAC_BITS > DATA_WIDTH - 2) ?
        {1'b0, {(DATA_WIDTH-1){1'b1}}} : (DATA_WIDTH'(1) << FRAC_BITS);

    // Kept column CELL, two banks (live and product), and right row CELL
    logic [DATA_WIDTH-1:0] r_k  [2][DIM];
    logic [DATA_WIDTH-1:0] r_rv [DIM];

    logic                  k_hit, r_hit;
    logic [RC_W-1:0]       k_slot, r_slot;
    logic [DATA_WIDTH-1:0] k_rd, r_rd;

    t_tok                    r_tok1, r_tok2;
    logic [RC_W-1:0]         r_r1, r_c1, r_r2, r_c2;
    logic signed [ACC_W-1:0] r_acc1, r_acc2;
    logic signed [2*DATA_WIDTH-1:0] r_prod;

    // Decode which slot of this cell an incoming element lands in
    always_comb begin
        k_hit  = 1'b0;
        r_hit  = 1'b0;
        k_slot = '0;
        r_slot = '0;
        for (int j = 0; j < DIM; j++) begin
            if (int'(i_wr.idx) == CELL * DIM + j) begin
                k_hit  = 1'b1;
                k_slot = RC_W'(j);
            end
            if (int'(i_wr.idx) == j * DIM + CELL) begin
                r_hit  = 1'b1;
                r_slot = RC_W'(j);
            end
        end
    end

    // Kept column storage: identity on reset, element writes, product writeback
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < 2; b++) begin
                for (int j = 0; j < DIM; j++) begin
                    r_k[b][j] <= (j == CELL) ? L_ONE : '0;
                end
            end
        end else begin
            if (i_wr.en && i_wr.mode == MODE_KEPT && k_hit) begin
                r_k[i_bank][k_slot] <= i_wr_value;
            end
            if (i_res_we) begin
                r_k[~i_bank][i_res_slot] <= i_res_value;
            end
        end
    end

    // Right operand row storage
    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.mode == MODE_RIGHT && r_hit) begin
            r_rv[r_slot] <= i_wr_value;
        end
    end

    // Operand selection for the token in hand
    assign k_rd = r_k[i_bank][i_r];
    assign r_rd = r_rv[i_c];

    // Stage 1: multiply; stage 2: accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1 <= '0;
            r_tok2 <= '0;
        end else if (i_en) begin
            r_tok1 <= i_tok;
            r_tok2 <= r_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r1   <= i_r;
            r_c1   <= i_c;
            r_acc1 <= i_acc;
            r_prod <= (2*DATA_WIDTH)'(signed'(k_rd)) * (2*DATA_WIDTH)'(signed'(r_rd));
            r_r2   <= r_r1;
            r_c2   <= r_c1;
            r_acc2 <= r_acc1 + ACC_W'(r_prod);
        end
    end

    assign o_tok = r_tok2;
    assign o_r   = r_r2;
    assign o_c   = r_c2;
    assign o_acc = r_acc2;

endmodule

>>> hw/rtl/mcm_seq.sv
// Sequencer that walks the product elements in column-major order.
module mcm_seq #(
    parameter int DIM  = 4,
    parameter int RC_W = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_en,
    input  logic                i_done,
    output logic                o_busy,
    output mcm_pkg::t_tok       o_tok,
    output logic [RC_W-1:0]     o_r,
    output logic [RC_W-1:0]     o_c
);
    import mcm_pkg::*;

    t_seq_state       r_state, n_state;
    logic [RC_W-1:0]  r_r, n_r, r_c, n_c;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             at_r_end, at_c_end;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_r     <= '0;
            r_c     <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_r     <= n_r;
            r_c     <= n_c;
            r_idx   <= n_idx;
        end
    end

    assign at_r_end = (r_r == RC_W'(DIM - 1));
    assign at_c_end = (r_c == RC_W'(DIM - 1));

    // Next state and token issue
    always_comb begin
        n_state = r_state;
        n_r     = r_r;
        n_c     = r_c;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_ISSUE;
                    n_r     = '0;
                    n_c     = '0;
                    n_idx   = '0;
                end
            end
            S_ISSUE: begin
                if (i_en) begin
                    n_idx = r_idx + IDX_W'(1);
                    if (at_r_end) begin
                        n_r = '0;
                        if (at_c_end) begin
                            n_state = S_DRAIN;
                        end else begin
                            n_c = r_c + RC_W'(1);
                        end
                    end else begin
                        n_r = r_r + RC_W'(1);
                    end
                end
            end
            S_DRAIN: begin
                if (i_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_tok.vld = (r_state == S_ISSUE);
    assign o_tok.last = at_r_end && at_c_end;
    assign o_tok.idx = r_idx;
    assign o_r       = r_r;
    assign o_c       = r_c;

endmodule

>>> hw/rtl/matrix_4x4_compose_multiply.sv
// Top level: kept-matrix compose-multiply over a chain of MAC cells.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_mode, i_index, i_value, i_last
//  output  | out       | o_valid / i_stall  | o_out_index, o_out_value, o_out_last
//
// A right-operand item with last set starts the product: DIM*DIM tokens enter the
// cell chain one per cycle while the output does not stall, and each passes 2*DIM
// cell stages plus the output register.
// The input stalls from the start of a product until its last element is
// loaded into the output register. A stalled output freezes the whole chain.
// Reset loads identity into the kept matrix; the right operand is not cleared.
`include "matrix_4x4_compose_multiply_defines.svh"

module matrix_4x4_compose_multiply #(
    parameter int DIM        = mcm_pkg::DIM_DEF,
    parameter int DATA_WIDTH = mcm_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mcm_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_mode,
    input  logic [mcm_pkg::IDX_W-1:0]   i_index,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mcm_pkg::IDX_W-1:0]   o_out_index,
    output logic signed [DATA_WIDTH-1:0] o_out_value,
    output logic                        o_out_last
);
    import mcm_pkg::*;

    localparam int RC_W  = $clog2(DIM);
    localparam int ACC_W = 2 * DATA_WIDTH + $clog2(DIM);
    localparam int NELEM = DIM * DIM;

    localparam logic signed [ACC_W-1:0] L_MAX =
        {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] L_MIN =
        {{(ACC_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    logic en, accept, start, done, busy;
    logic r_bank;
    t_wr  wr;

    t_tok                    tok_ch [DIM+1];
    logic [RC_W-1:0]         r_ch   [DIM+1];
    logic [RC_W-1:0]         c_ch   [DIM+1];
    logic signed [ACC_W-1:0] acc_ch [DIM+1];
    logic [DIM-1:0]          chain_vld;

    logic signed [ACC_W-1:0]      shifted;
    logic signed [DATA_WIDTH-1:0] sat_val;

    logic                         r_o_valid;
    logic [IDX_W-1:0]             r_o_index;
    logic signed [DATA_WIDTH-1:0] r_o_value;
    logic                         r_o_last;

    // Handshake decode
    assign en     = !r_o_valid || !i_stall;
    assign accept = i_valid && !busy;
    assign start  = accept && (i_mode == MODE_RIGHT) && i_last;
    assign done   = en && tok_ch[DIM].vld && tok_ch[DIM].last;
    assign o_stall = busy;

    assign wr.en   = accept;
    assign wr.mode = i_mode;
    assign wr.idx  = i_index;

    // Element order sequencer
    mcm_seq #(
        .DIM  (DIM),
        .RC_W (RC_W)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_en    (en),
        .i_done  (done),
        .o_busy  (busy),
        .o_tok   (tok_ch[0]),
        .o_r     (r_ch[0]),
        .o_c     (c_ch[0])
    );

    assign acc_ch[0] = '0;

    // Chain of cells, cell k adds term k of each dot product
    for (genvar k = 0; k < DIM; k++) begin : g_cell
        mcm_cell #(
            .DIM        (DIM),
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .CELL       (k),
            .RC_W       (RC_W),
            .ACC_W      (ACC_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (en),
            .i_bank      (r_bank),
            .i_wr        (wr),
            .i_wr_value  (i_value),
            .i_res_we    (en && tok_ch[DIM].vld && (c_ch[DIM] == RC_W'(k))),
            .i_res_slot  (r_ch[DIM]),
            .i_res_value (sat_val),
            .i_tok       (tok_ch[k]),
            .i_r         (r_ch[k]),
            .i_c         (c_ch[k]),
            .i_acc       (acc_ch[k]),
            .o_tok       (tok_ch[k+1]),
            .o_r         (r_ch[k+1]),
            .o_c         (c_ch[k+1]),
            .o_acc       (acc_ch[k+1])
        );
        assign chain_vld[k] = tok_ch[k+1].vld;
    end

    // Scale down by the fraction bits (floor) and saturate
    assign shifted = acc_ch[DIM] >>> FRAC_BITS;

    always_comb begin
        if (shifted > L_MAX) begin
            sat_val = L_MAX[DATA_WIDTH-1:0];
        end else if (shifted < L_MIN) begin
            sat_val = L_MIN[DATA_WIDTH-1:0];
        end else begin
            sat_val = shifted[DATA_WIDTH-1:0];
        end
    end

    // Bank swap once the whole product sits in the spare bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
        end else if (done) begin
            r_bank <= ~r_bank;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= tok_ch[DIM].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_index <= tok_ch[DIM].idx;
            r_o_value <= sat_val;
            r_o_last  <= tok_ch[DIM].last;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_index = r_o_index;
    assign o_out_value = r_o_value;
    assign o_out_last  = r_o_last;

    // Checks
    `MCM_ASSERT_IMP(a_last_index, i_clk, i_rst_n, o_valid && o_out_last, o_out_index == IDX_W'(NELEM - 1))
    `MCM_ASSERT_NXT(a_bank_hold, i_clk, i_rst_n, !done, $stable(r_bank))
    `MCM_ASSERT_IMP(a_idle_empty, i_clk, i_rst_n, !o_stall, chain_vld == '0)

endmodule
